>>> src/stream_group_reverser_defines.svh
// Assertion helpers shared by the stream group reverser modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef STREAM_GROUP_REVERSER_DEFINES_SVH
`define STREAM_GROUP_REVERSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sgr_pkg.sv
package sgr_pkg;

  // Width of one stream value.
  localparam int unsigned ValueW = 32;

  // Width of the group size register.
  localparam int unsigned CfgW = 5;

  // Group completion notice from the front to the descriptor queue.
  typedef struct packed {
    logic push;
    logic bank;
    logic last;
  } grp_ctl_t;

  // Bank release notice from the back to the front.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

>>> src/stream_group_reverser.sv
// Stream group reverser.
// Input stream (s_axis): tdata carries a signed 32-bit value, tlast marks the
// last value of a list. Output stream (m_axis): tdata carries the value, tuser
// is set on the last result caused by one input, tlast on the final result of
// a list. cfg_we_i writes the group size (1..MAX_GROUP; 0 acts as 1, larger
// values saturate); the user must use it only while the block is idle, which
// the block itself does not enforce. Values are buffered until a group fills
// or the list ends; the group then leaves in reverse order. While the receiver
// is ready, the group drains at one result a cycle, and since two buffer banks
// alternate, filling one group overlaps draining the previous one: sustained
// throughput is one item per cycle, limited by the single read port of the
// group buffer. Input stalls only when both banks still hold groups
// waiting to drain.
// Reset clears the fill count, the bank ownership and the output valid, and
// sets the group size to 1. A stalled receiver holds the output register; the
// back stops reading and the front stalls once both banks are taken.
module stream_group_reverser #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_out
  output logic        m_axis_tuser,   // [0] run_last
  output logic        m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(MAX_GROUP);
  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);
  localparam int unsigned DescW = CntW + 2;

  logic [sgr_pkg::CfgW-1:0]   group_size_q;
  logic                       wr_en;
  logic [IdxW:0]              wr_addr;
  logic [sgr_pkg::ValueW-1:0] wr_data;
  sgr_pkg::grp_ctl_t          grp;
  logic [CntW-1:0]            grp_count;
  sgr_pkg::rel_t              rel;
  logic                       head_valid;
  logic [DescW-1:0]           head_data;
  logic                       head_pop;

  // Group size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= sgr_pkg::CfgW'(1);
    end else if (cfg_we_i) begin
      group_size_q <= cfg_wdata_i;
    end
  end

  sgr_front #(
    .MAX_GROUP(MAX_GROUP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .group_size_i (group_size_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .grp_o        (grp),
    .grp_count_o  (grp_count),
    .rel_i        (rel)
  );

  // Descriptor queue: {count, bank, list end}.
  sgr_fifo #(
    .DataW(DescW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (grp.push),
    .push_data_i  ({grp_count, grp.bank, grp.last}),
    .pop_i        (head_pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  sgr_back #(
    .MAX_GROUP(MAX_GROUP)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .wr_data_i       (wr_data),
    .grp_valid_i     (head_valid),
    .grp_bank_i      (head_data[1]),
    .grp_last_i      (head_data[0]),
    .grp_count_i     (head_data[DescW-1:2]),
    .grp_pop_o       (head_pop),
    .rel_o           (rel),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_value_o     (m_axis_tdata),
    .out_run_last_o  (m_axis_tuser),
    .out_list_done_o (m_axis_tlast)
  );

endmodule

>>> src/sgr_front.sv
`include "stream_group_reverser_defines.svh"

module sgr_front #(
  parameter int unsigned MAX_GROUP = 16,
  localparam int unsigned IdxW = $clog2(MAX_GROUP),
  localparam int unsigned CntW = $clog2(MAX_GROUP + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sgr_pkg::CfgW-1:0]    group_size_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sgr_pkg::ValueW-1:0]  in_value_i,
  input  logic                        in_last_i,
  output logic                        wr_en_o,
  output logic [IdxW:0]               wr_addr_o,
  output logic [sgr_pkg::ValueW-1:0]  wr_data_o,
  output sgr_pkg::grp_ctl_t           grp_o,
  output logic [CntW-1:0]             grp_count_o,
  input  sgr_pkg::rel_t               rel_i
);

  localparam int unsigned CmpW = (CntW > sgr_pkg::CfgW) ? CntW : sgr_pkg::CfgW;

  logic [CntW-1:0] fill_q, fill_d;
  logic            wbank_q, wbank_d;
  logic [1:0]      busy_q, busy_d;
  logic [CmpW-1:0] size_ext;
  logic [CntW-1:0] size_eff;
  logic [CntW-1:0] fill_next;
  logic            accept;
  logic            flush;

  // Effective group size: zero acts as one, large values saturate.
  always_comb begin
    size_ext = CmpW'(group_size_i);
    if (size_ext == '0) begin
      size_ext = CmpW'(1);
    end else if (size_ext > CmpW'(MAX_GROUP)) begin
      size_ext = CmpW'(MAX_GROUP);
    end
    size_eff = size_ext[CntW-1:0];
  end

  // A bank can be filled only once the back has finished reading it.
  assign in_ready_o = !busy_q[wbank_q];
  assign accept     = in_valid_i && in_ready_o;
  assign fill_next  = fill_q + CntW'(1);
  assign flush      = in_last_i || (fill_next >= size_eff);

  // Buffer write port: each accepted item goes to the current bank.
  assign wr_en_o   = accept;
  assign wr_addr_o = {wbank_q, fill_q[IdxW-1:0]};
  assign wr_data_o = in_value_i;

  // Group descriptor handed to the queue when a group closes.
  assign grp_o.push   = accept && flush;
  assign grp_o.bank   = wbank_q;
  assign grp_o.last   = in_last_i;
  assign grp_count_o  = fill_next;

  // Fill counter, bank select and bank ownership.
  always_comb begin
    fill_d  = fill_q;
    wbank_d = wbank_q;
    busy_d  = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (flush) begin
        fill_d          = '0;
        wbank_d         = !wbank_q;
        busy_d[wbank_q] = 1'b1;
      end else begin
        fill_d = fill_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

  `SGR_ASSERT_IMP(a_fill_bound, 1'b1, fill_q < CntW'(MAX_GROUP), "fill count reached depth")
  `SGR_ASSERT_NXT(a_bank_swap, grp_o.push, wbank_q != $past(wbank_q), "bank did not swap")
  `SGR_ASSERT_IMP(a_rel_busy, rel_i.valid, busy_q[rel_i.bank], "release of an idle bank")

endmodule

>>> src/sgr_fifo.sv
`include "stream_group_reverser_defines.svh"

module sgr_fifo #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [DataW-1:0] head_data_o
);

  logic [DataW-1:0] ent_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign head_valid_o = cnt_q != 2'd0;
  assign head_data_o  = ent_q[rptr_q];

  // Occupancy tracking.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

  `SGR_ASSERT_IMP(a_no_overflow, push_i, (cnt_q != 2'd2) || pop_i, "descriptor queue overflow")
  `SGR_ASSERT_IMP(a_no_underflow, pop_i, cnt_q != 2'd0, "pop from empty queue")

endmodule

>>> src/sgr_back.sv
`include "stream_group_reverser_defines.svh"

module sgr_back #(
  parameter int unsigned MAX_GROUP = 16,
  localparam int unsigned IdxW = $clog2(MAX_GROUP),
  localparam int unsigned CntW = $clog2(MAX_GROUP + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [IdxW:0]               wr_addr_i,
  input  logic [sgr_pkg::ValueW-1:0]  wr_data_i,
  input  logic                        grp_valid_i,
  input  logic                        grp_bank_i,
  input  logic                        grp_last_i,
  input  logic [CntW-1:0]             grp_count_i,
  output logic                        grp_pop_o,
  output sgr_pkg::rel_t               rel_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sgr_pkg::ValueW-1:0]  out_value_o,
  output logic                        out_run_last_o,
  output logic                        out_list_done_o
);

  // Each bank spans a power of two so that {bank, index} always addresses it.
  logic [sgr_pkg::ValueW-1:0] mem_q [2**(IdxW+1)];
  logic [sgr_pkg::ValueW-1:0] rd_data_q;
  logic                       out_valid_q;
  logic                       run_last_q;
  logic                       list_done_q;
  logic [CntW-1:0]            off_q;
  logic [CntW-1:0]            idx;
  logic                       fin;
  logic                       issue;

  // Walk the head group from its newest entry down to its oldest.
  assign idx   = grp_count_i - CntW'(1) - off_q;
  assign fin   = idx == '0;
  assign issue = grp_valid_i && (!out_valid_q || out_ready_i);

  assign grp_pop_o   = issue && fin;
  assign rel_o.valid = issue && fin;
  assign rel_o.bank  = grp_bank_i;

  // Group buffer: two banks, written by the front, read here.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The registered read data is the output register.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q   <= mem_q[{grp_bank_i, idx[IdxW-1:0]}];
      run_last_q  <= fin;
      list_done_q <= fin && grp_last_i;
    end
  end

  // Output valid and position within the group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      off_q       <= '0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
        off_q       <= fin ? '0 : off_q + CntW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_value_o     = rd_data_q;
  assign out_run_last_o  = run_last_q;
  assign out_list_done_o = list_done_q;

  `SGR_ASSERT_IMP(a_grp_count, grp_valid_i,
    (grp_count_i != '0) && (off_q < grp_count_i), "bad group position")

endmodule

>>> test/tb_stream_group_reverser.sv
module tb_stream_group_reverser;

  localparam int unsigned MaxGroup   = 16;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainWait  = 8;

  // One list element as it enters the block.
  typedef struct packed {
    logic [sgr_pkg::ValueW-1:0] value;
    logic                       list_end;
  } list_item_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [sgr_pkg::ValueW-1:0] value;
    logic                       run_last;
    logic                       list_done;
  } rev_result_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [sgr_pkg::CfgW-1:0]   cfg_wdata_i   = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [sgr_pkg::ValueW-1:0] s_axis_tdata  = '0;
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [sgr_pkg::ValueW-1:0] m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       m_axis_tlast;

  list_item_t  pending_items[$];
  rev_result_t expected_values[$];

  // Our own copy of the block state, kept in step with accepted transfers.
  logic [sgr_pkg::ValueW-1:0] group_buf [MaxGroup];
  int unsigned                fill_cnt          = 0;
  logic [sgr_pkg::CfgW-1:0]   group_size_shadow = 5'd1;

  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 77;
  int unsigned err_count     = 0;
  int unsigned stall_cycles  = 0;

  stream_group_reverser #(
    .MAX_GROUP(MaxGroup)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] value
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [31:0] value_out
    .m_axis_tuser (m_axis_tuser),   // [0] run_last
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // A group size of zero acts as one; sizes beyond the buffer saturate.
  function automatic int unsigned group_limit(logic [sgr_pkg::CfgW-1:0] size);
    if (size == '0) begin
      return 1;
    end
    if (size > MaxGroup) begin
      return MaxGroup;
    end
    return int'(size);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s, got %h, expected %h", what, got, want);
    err_count++;
  endtask

  task automatic add_item(logic [31:0] value, logic list_end);
    list_item_t it;
    it.value    = value;
    it.list_end = list_end;
    pending_items = {pending_items, it};
  endtask

  task automatic write_group_size(logic [sgr_pkg::CfgW-1:0] size);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Wait for all items to go in and all results to come out, then let the
  // pipeline settle so that the block is idle.
  task automatic wait_block_idle();
    do begin
      @(posedge clk_i);
    end while (pending_items.size() != 0 || s_axis_tvalid || expected_values.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Queue whole lists of random lengths until at least count items are queued.
  // Lengths favor single items, exact groups and several full groups.
  task automatic queue_random_lists(int unsigned count);
    int unsigned grp;
    int unsigned len;
    int unsigned added;
    logic [31:0] value;
    grp   = group_limit(group_size_shadow);
    added = 0;
    while (added < count) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = grp;
        2: len = grp * $urandom_range(2, 3);
        default: len = $urandom_range(1, 3 * grp + 2);
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = 32'h0000_0000;
          3: value = 32'hffff_ffff;
          default: value = $urandom;
        endcase
        add_item(value, i == len - 1);
      end
      added += len;
    end
  endtask

  // Driver: offers queued items and predicts the results of each transfer.
  always @(posedge clk_i) begin : driver
    list_item_t  nxt;
    rev_result_t res;
    int unsigned limit;
    if (!rst_ni) begin
      s_axis_tvalid     <= 1'b0;
      fill_cnt          = 0;
      group_size_shadow = 5'd1;
    end else begin
      if (cfg_we_i) begin
        group_size_shadow = cfg_wdata_i;
      end
      // A transfer that fills the group or ends the list releases the
      // group newest first.
      if (s_axis_tvalid && s_axis_tready) begin
        limit = group_limit(group_size_shadow);
        group_buf[fill_cnt] = s_axis_tdata;
        fill_cnt++;
        if (fill_cnt >= limit || s_axis_tlast) begin
          for (int unsigned k = 0; k < fill_cnt; k++) begin
            res.value     = group_buf[fill_cnt - 1 - k];
            res.run_last  = (k == fill_cnt - 1);
            res.list_done = (k == fill_cnt - 1) && s_axis_tlast;
            expected_values = {expected_values, res};
          end
          fill_cnt = 0;
        end
      end
      // Present the next item once the current one has gone.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.value;
          s_axis_tlast  <= nxt.list_end;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transfer against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    rev_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_values.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, '0);
        end else begin
          want = expected_values.pop_front();
          if (m_axis_tdata !== want.value) begin
            report_mismatch("value_out", m_axis_tdata, want.value);
          end
          if (m_axis_tuser !== want.run_last) begin
            report_mismatch("run_last", 32'(m_axis_tuser), 32'(want.run_last));
          end
          if (m_axis_tlast !== want.list_done) begin
            report_mismatch("list_done", 32'(m_axis_tlast), 32'(want.list_done));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("timeout: no transfer for %0d cycles", stall_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus: directed cases first, then random lists over several settings.
  initial begin
    int unsigned send_plan [3];
    int unsigned recv_plan [3];
    logic [sgr_pkg::CfgW-1:0] size_plan [12];
    send_plan = '{17, 77, 0};
    recv_plan = '{77, 17, 0};
    size_plan = '{5'd16, 5'd31, 5'd2, 5'd17, 5'd0, 5'd7,
                  5'd1, 5'd3, 5'd8, 5'd15, 5'd4, 5'd6};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pass-through at the reset size, with the extreme values.
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7fff_ffff, 1'b1);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'hffff_ffff, 1'b1);
    wait_block_idle();

    // A group size of zero still passes items through.
    write_group_size(5'd0);
    add_item(32'h1234_5678, 1'b0);
    add_item(32'hfedc_ba98, 1'b1);
    wait_block_idle();

    // One full group of three, then a short group closed by the list end.
    write_group_size(5'd3);
    add_item(32'h0000_0001, 1'b0);
    add_item(32'h0000_0002, 1'b0);
    add_item(32'h0000_0003, 1'b0);
    add_item(32'h5555_5555, 1'b0);
    add_item(32'haaaa_aaaa, 1'b1);
    wait_block_idle();

    // Lower the group size while three items are held: the next item
    // flushes all four.
    write_group_size(5'd5);
    add_item(32'h1111_1111, 1'b0);
    add_item(32'h2222_2222, 1'b0);
    add_item(32'h3333_3333, 1'b0);
    wait_block_idle();
    write_group_size(5'd2);
    add_item(32'h4444_4444, 1'b0);
    add_item(32'h6666_6666, 1'b1);
    wait_block_idle();

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_plan[m];
      recv_idle_pct = recv_plan[m];
      for (int p = 0; p < 4; p++) begin
        write_group_size(size_plan[m * 4 + p]);
        queue_random_lists(30);
        wait_block_idle();
      end
    end

    if (expected_values.size() != 0) begin
      report_mismatch("results never delivered", '0, 32'(expected_values.size()));
    end
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> stream_group_reverser.f
+incdir+src
src/sgr_pkg.sv
src/sgr_front.sv
src/sgr_fifo.sv
src/sgr_back.sv
src/stream_group_reverser.sv
test/tb_stream_group_reverser.sv
